FILE: sv/scle_pkg.sv
// Shared types, constants and key tables for the scancode line editor.
package scle_pkg;

	localparam int LINE_BYTES     = 128;
	localparam int TERMINAL_COUNT = 3;
	localparam int IDX_W          = $clog2(LINE_BYTES);
	localparam int TERM_W         = 2;
	localparam int STORE_DEPTH    = TERMINAL_COUNT * LINE_BYTES;
	localparam int ADDR_W         = $clog2(STORE_DEPTH);
	localparam int MAP_LEN        = 58;

	// Scancodes with a meaning of their own
	localparam logic [7:0] SC_LSHIFT_UP = 8'hAA;
	localparam logic [7:0] SC_RSHIFT_UP = 8'hB6;
	localparam logic [7:0] SC_ALT_UP    = 8'hB8;
	localparam logic [7:0] SC_CTRL_UP   = 8'h9D;
	localparam logic [7:0] SC_ENTER     = 8'd28;
	localparam logic [7:0] SC_ALT       = 8'd56;
	localparam logic [7:0] SC_CTRL      = 8'd29;
	localparam logic [7:0] SC_LSHIFT    = 8'd42;
	localparam logic [7:0] SC_RSHIFT    = 8'd54;
	localparam logic [7:0] SC_BKSP      = 8'd14;
	localparam logic [7:0] SC_CAPS      = 8'd58;
	localparam logic [7:0] SC_F1        = 8'h3B;
	localparam logic [7:0] SC_F3        = 8'h3D;

	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_LOW_L   = 8'h6C;
	localparam logic [7:0] CH_UP_L    = 8'h4C;
	localparam logic [7:0] CH_LOW_A   = 8'h61;
	localparam logic [7:0] CH_LOW_Z   = 8'h7A;

	typedef enum logic [1:0] {
		REQ_SCAN    = 2'd0,
		REQ_READ    = 2'd1,
		REQ_CONSUME = 2'd2
	} req_t;

	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_CHAR    = 3'd1,
		EV_NEWLINE = 3'd2,
		EV_BKSP    = 3'd3,
		EV_CLEAR   = 3'd4,
		EV_SWITCH  = 3'd5,
		EV_READ    = 3'd6
	} ev_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_ENTER,
		ACT_BKSP,
		ACT_CHAR,
		ACT_SWITCH,
		ACT_WIPE
	} act_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_READ,
		ST_WIPE,
		ST_RESPOND
	} state_t;

	typedef struct packed {
		logic shift;
		logic ctrl;
		logic alt;
		logic caps;
	} mods_t;

	typedef struct packed {
		act_t              act;
		logic [7:0]        ch;
		logic [TERM_W-1:0] target;
		mods_t             mods;
	} key_dec_t;

	// Flat store address of a byte in a terminal's line
	function automatic logic [ADDR_W-1:0] line_addr(input logic [TERM_W-1:0] t,
		input logic [IDX_W-1:0] i);
		return ADDR_W'(t) * ADDR_W'(LINE_BYTES) + ADDR_W'(i);
	endfunction

	// Unshifted US layout
	function automatic logic [7:0] plain_char(input logic [5:0] c);
		logic [7:0] r;
		case (c)
			6'd1:  r = 8'h1B;
			6'd2:  r = 8'h31;
			6'd3:  r = 8'h32;
			6'd4:  r = 8'h33;
			6'd5:  r = 8'h34;
			6'd6:  r = 8'h35;
			6'd7:  r = 8'h36;
			6'd8:  r = 8'h37;
			6'd9:  r = 8'h38;
			6'd10: r = 8'h39;
			6'd11: r = 8'h30;
			6'd12: r = 8'h2D;
			6'd13: r = 8'h3D;
			6'd14: r = 8'h08;
			6'd15: r = 8'h20;
			6'd16: r = 8'h71;
			6'd17: r = 8'h77;
			6'd18: r = 8'h65;
			6'd19: r = 8'h72;
			6'd20: r = 8'h74;
			6'd21: r = 8'h79;
			6'd22: r = 8'h75;
			6'd23: r = 8'h69;
			6'd24: r = 8'h6F;
			6'd25: r = 8'h70;
			6'd26: r = 8'h5B;
			6'd27: r = 8'h5D;
			6'd28: r = 8'h0A;
			6'd30: r = 8'h61;
			6'd31: r = 8'h73;
			6'd32: r = 8'h64;
			6'd33: r = 8'h66;
			6'd34: r = 8'h67;
			6'd35: r = 8'h68;
			6'd36: r = 8'h6A;
			6'd37: r = 8'h6B;
			6'd38: r = 8'h6C;
			6'd39: r = 8'h3B;
			6'd40: r = 8'h27;
			6'd41: r = 8'h60;
			6'd43: r = 8'h5C;
			6'd44: r = 8'h7A;
			6'd45: r = 8'h78;
			6'd46: r = 8'h63;
			6'd47: r = 8'h76;
			6'd48: r = 8'h62;
			6'd49: r = 8'h6E;
			6'd50: r = 8'h6D;
			6'd51: r = 8'h2C;
			6'd52: r = 8'h2E;
			6'd53: r = 8'h2F;
			6'd55: r = 8'h2A;
			6'd57: r = 8'h20;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// Shifted US layout
	function automatic logic [7:0] shift_char(input logic [5:0] c);
		logic [7:0] r;
		case (c)
			6'd1:  r = 8'h1B;
			6'd2:  r = 8'h21;
			6'd3:  r = 8'h40;
			6'd4:  r = 8'h23;
			6'd5:  r = 8'h24;
			6'd6:  r = 8'h25;
			6'd7:  r = 8'h5E;
			6'd8:  r = 8'h26;
			6'd9:  r = 8'h2A;
			6'd10: r = 8'h28;
			6'd11: r = 8'h29;
			6'd12: r = 8'h5F;
			6'd13: r = 8'h2B;
			6'd14: r = 8'h08;
			6'd15: r = 8'h20;
			6'd16: r = 8'h51;
			6'd17: r = 8'h57;
			6'd18: r = 8'h45;
			6'd19: r = 8'h52;
			6'd20: r = 8'h54;
			6'd21: r = 8'h59;
			6'd22: r = 8'h55;
			6'd23: r = 8'h49;
			6'd24: r = 8'h4F;
			6'd25: r = 8'h50;
			6'd26: r = 8'h7B;
			6'd27: r = 8'h7D;
			6'd28: r = 8'h0A;
			6'd30: r = 8'h41;
			6'd31: r = 8'h53;
			6'd32: r = 8'h44;
			6'd33: r = 8'h46;
			6'd34: r = 8'h47;
			6'd35: r = 8'h48;
			6'd36: r = 8'h4A;
			6'd37: r = 8'h4B;
			6'd38: r = 8'h4C;
			6'd39: r = 8'h3A;
			6'd40: r = 8'h22;
			6'd41: r = 8'h7E;
			6'd43: r = 8'h7C;
			6'd44: r = 8'h5A;
			6'd45: r = 8'h58;
			6'd46: r = 8'h43;
			6'd47: r = 8'h56;
			6'd48: r = 8'h42;
			6'd49: r = 8'h4E;
			6'd50: r = 8'h4D;
			6'd51: r = 8'h3C;
			6'd52: r = 8'h3E;
			6'd53: r = 8'h3F;
			6'd55: r = 8'h2A;
			6'd57: r = 8'h20;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

FILE: sv/scle_line_ram.sv
// Line store: single-port synchronous RAM with registered read data.
module scle_line_ram (
	input  logic                       clk,
	input  logic                       we,
	input  logic                       re,
	input  logic [scle_pkg::ADDR_W-1:0] addr,
	input  logic [7:0]                 wdata,
	output logic [7:0]                 rdata
);
	import scle_pkg::*;

	logic [7:0] mem [STORE_DEPTH];

	// Write takes the port; otherwise read into the output register
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

FILE: sv/scle_key_decode.sv
// Scancode decoder: modifier tracking, key translation and action choice.
module scle_key_decode (
	input  logic [7:0]          code,
	input  scle_pkg::mods_t     mods_in,
	input  logic                idx_zero,
	input  logic                idx_full,
	output scle_pkg::key_dec_t  dec
);
	import scle_pkg::*;

	logic [7:0] plain_c;
	logic [7:0] shift_c;
	logic [7:0] diff;
	logic       letter;

	// Look up both layouts; codes past the table give nothing
	always_comb begin
		plain_c = (code < 8'(MAP_LEN)) ? plain_char(code[5:0]) : 8'h00;
		shift_c = (code < 8'(MAP_LEN)) ? shift_char(code[5:0]) : 8'h00;
		diff    = code - SC_F1;
		letter  = (plain_c >= CH_LOW_A) && (plain_c <= CH_LOW_Z);
	end

	// Choose the action and the modifier flags left behind
	always_comb begin
		dec.act    = ACT_NONE;
		dec.ch     = 8'h00;
		dec.target = diff[TERM_W-1:0];
		dec.mods   = mods_in;

		// releases drop modifiers
		if (code == SC_LSHIFT_UP || code == SC_RSHIFT_UP) dec.mods.shift = 1'b0;
		if (code == SC_ALT_UP) dec.mods.alt = 1'b0;
		if (code == SC_CTRL_UP) dec.mods.ctrl = 1'b0;

		if (code == SC_ENTER) begin
			dec.act = ACT_ENTER;
			dec.ch  = CH_NEWLINE;
		end else begin
			if (code == SC_ALT) dec.mods.alt = 1'b1;
			if (code == SC_CTRL) dec.mods.ctrl = 1'b1;
			if (code == SC_LSHIFT || code == SC_RSHIFT) dec.mods.shift = 1'b1;

			if (code == SC_BKSP) begin
				if (!idx_zero) dec.act = ACT_BKSP;
			end else if (dec.mods.alt && code >= SC_F1 && code <= SC_F3) begin
				if (int'(diff) < TERMINAL_COUNT) dec.act = ACT_SWITCH;
			end else if (code != 8'h00 && !code[7]) begin
				if (dec.mods.ctrl && (plain_c == CH_LOW_L || shift_c == CH_UP_L)) begin
					dec.act = ACT_WIPE;
				end else begin
					if (code == SC_CAPS) dec.mods.caps = ~dec.mods.caps;
					if (plain_c != 8'h00 && !idx_full) begin
						dec.act = ACT_CHAR;
						if (letter) begin
							dec.ch = (dec.mods.caps ^ dec.mods.shift) ? shift_c : plain_c;
						end else begin
							dec.ch = dec.mods.shift ? shift_c : plain_c;
						end
					end
				end
			end
		end
	end

endmodule

FILE: sv/scancode_line_editor_unit.sv
// Top level: request sequencer around the line store and key decoder.
//
// Requests enter on start while busy is low: req_type picks a scancode,
// a read of one stored byte (read_position) or a consume of the active
// line. Exactly one result follows each request, shown for one cycle with
// done high: event_res, char_out, and the active terminal's fill_count and
// line_ready as they stand after the request. The receiver cannot stall;
// each result is taken in its done cycle.
// A scancode that clears nothing passes through DECODE to RESPOND; a read
// passes through READ as well, for the registered RAM read. A line clear
// (ctrl+L or consume) walks the 128 bytes of that line in WIPE, one RAM
// write a cycle, before RESPOND. The next request may be accepted in the
// cycle after done; no new request is taken until the last one is through.
// After reset the whole 384-byte store is zeroed, one byte a cycle, and
// busy stays high until that is done.
module scancode_line_editor_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] req_type,
	input  logic [7:0] scancode,
	input  logic [6:0] read_position,
	output logic       done,
	output logic [2:0] event_res,
	output logic [7:0] char_out,
	output logic [1:0] terminal,
	output logic [6:0] fill_count,
	output logic       line_ready
);
	import scle_pkg::*;

	state_t             state_q, state_d;
	logic [1:0]         req_q;
	logic [7:0]         code_q;
	logic [6:0]         pos_q;
	ev_t                ev_q;
	logic [7:0]         char_q;
	mods_t              mods_q;
	logic [TERM_W-1:0]  term_q;
	logic [IDX_W-1:0]   widx_q [TERMINAL_COUNT];
	logic               done_q [TERMINAL_COUNT];
	logic [ADDR_W-1:0]  clr_q;
	logic [IDX_W-1:0]   wipe_q;
	logic [IDX_W-1:0]   cur_idx;
	logic               pos_oob;
	key_dec_t           dec;
	logic               ram_we;
	logic               ram_re;
	logic [ADDR_W-1:0]  ram_addr;
	logic [7:0]         ram_wdata;
	logic [7:0]         ram_rdata;

	assign cur_idx = widx_q[term_q];
	assign pos_oob = int'(pos_q) >= LINE_BYTES;

	scle_key_decode u_dec (
		.code     (code_q),
		.mods_in  (mods_q),
		.idx_zero (cur_idx == '0),
		.idx_full (cur_idx == IDX_W'(LINE_BYTES - 1)),
		.dec      (dec)
	);

	scle_line_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == ADDR_W'(STORE_DEPTH - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				case (req_q)
					REQ_READ:    state_d = ST_READ;
					REQ_CONSUME: state_d = ST_WIPE;
					REQ_SCAN:    state_d = (dec.act == ACT_WIPE) ? ST_WIPE : ST_RESPOND;
					default:     state_d = ST_RESPOND;
				endcase
			end
			ST_READ: state_d = ST_RESPOND;
			ST_WIPE: begin
				if (wipe_q == IDX_W'(LINE_BYTES - 1)) state_d = ST_RESPOND;
			end
			ST_RESPOND: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// RAM port and handshake outputs
	always_comb begin
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_addr  = line_addr(term_q, cur_idx);
		ram_wdata = 8'h00;
		case (state_q)
			ST_CLEAR: begin
				ram_we   = 1'b1;
				ram_addr = clr_q;
			end
			ST_DECODE: begin
				if (req_q == REQ_SCAN && (dec.act == ACT_ENTER || dec.act == ACT_BKSP ||
					dec.act == ACT_CHAR)) begin
					ram_we    = 1'b1;
					ram_wdata = (dec.act == ACT_BKSP) ? 8'h00 : dec.ch;
				end else if (req_q == REQ_READ) begin
					ram_re   = 1'b1;
					ram_addr = line_addr(term_q, IDX_W'(pos_q));
				end
			end
			ST_WIPE: begin
				ram_we   = 1'b1;
				ram_addr = line_addr(term_q, wipe_q);
			end
			default: begin
			end
		endcase
		busy       = (state_q != ST_IDLE);
		done       = (state_q == ST_RESPOND);
		event_res  = ev_q;
		char_out   = char_q;
		terminal   = term_q;
		fill_count = 7'(cur_idx);
		line_ready = done_q[term_q];
	end

	// Control state: sequencer, flags, per-terminal index and ready marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			mods_q  <= '0;
			term_q  <= '0;
			clr_q   <= '0;
			wipe_q  <= '0;
			for (int i = 0; i < TERMINAL_COUNT; i++) begin
				widx_q[i] <= '0;
				done_q[i] <= 1'b0;
			end
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + ADDR_W'(1);
				ST_DECODE: begin
					wipe_q <= '0;
					if (req_q == REQ_SCAN) begin
						mods_q <= dec.mods;
						case (dec.act)
							ACT_ENTER:  done_q[term_q] <= 1'b1;
							ACT_BKSP:   widx_q[term_q] <= cur_idx - IDX_W'(1);
							ACT_CHAR:   widx_q[term_q] <= cur_idx + IDX_W'(1);
							ACT_SWITCH: term_q <= dec.target;
							ACT_WIPE:   widx_q[term_q] <= '0;
							default: begin
							end
						endcase
					end else if (req_q == REQ_CONSUME) begin
						widx_q[term_q] <= '0;
						done_q[term_q] <= 1'b0;
					end
				end
				ST_WIPE: wipe_q <= wipe_q + IDX_W'(1);
				default: begin
				end
			endcase
		end
	end

	// Request capture and result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			req_q  <= req_type;
			code_q <= scancode;
			pos_q  <= read_position;
		end
		if (state_q == ST_DECODE) begin
			// pass the character on for a newline or an appended key
			char_q <= (req_q == REQ_SCAN && (dec.act == ACT_ENTER || dec.act == ACT_CHAR)) ?
				dec.ch : 8'h00;
			case (req_q)
				REQ_SCAN: begin
					case (dec.act)
						ACT_ENTER:  ev_q <= EV_NEWLINE;
						ACT_BKSP:   ev_q <= EV_BKSP;
						ACT_CHAR:   ev_q <= EV_CHAR;
						ACT_SWITCH: ev_q <= EV_SWITCH;
						ACT_WIPE:   ev_q <= EV_CLEAR;
						default:    ev_q <= EV_NONE;
					endcase
				end
				REQ_READ:    ev_q <= EV_READ;
				REQ_CONSUME: ev_q <= EV_CLEAR;
				default:     ev_q <= EV_NONE;
			endcase
		end
		// take the read byte from the RAM output register
		if (state_q == ST_READ) begin
			char_q <= pos_oob ? 8'h00 : ram_rdata;
		end
	end

endmodule

FILE: test/tb_scancode_line_editor_unit.sv
// Self-checking bench for the scancode line editor with a shadow model in a class.
`timescale 1ns / 1ps

module tb_scancode_line_editor_unit;

	import scle_pkg::*;

	// Request code the block ignores
	localparam logic [1:0] REQ_UNKNOWN = 2'd3;

	// Key codes used by the directed part
	localparam logic [7:0] SC_KEY_1     = 8'd2;
	localparam logic [7:0] SC_KEY_A     = 8'd30;
	localparam logic [7:0] SC_KEY_L     = 8'd38;
	localparam logic [7:0] SC_SPACE     = 8'd57;
	localparam logic [7:0] SC_F2        = 8'h3C;
	localparam logic [7:0] SC_PAST_MAP  = 8'd100;
	localparam logic [7:0] SC_NULL      = 8'h00;
	localparam logic [7:0] SC_ANY_UP    = 8'hFF;
	localparam logic [7:0] SC_LOWEST_UP = 8'h80;

	typedef struct {
		ev_t        ev;
		logic [7:0] ch;
		logic [1:0] term;
		logic [6:0] fill;
		logic       ready;
	} echo_t;

	// Shadow of the editor: modifiers, line stores and the echoes still awaited
	class line_editor_shadow;
		logic              shift_dn, ctrl_dn, alt_dn, caps_lk;
		logic [1:0]        active;
		logic [7:0]        lines [TERMINAL_COUNT][LINE_BYTES];
		logic [6:0]        widx [TERMINAL_COUNT];
		logic              ready [TERMINAL_COUNT];
		logic [7:0]        plain_map [MAP_LEN];
		logic [7:0]        upper_map [MAP_LEN];
		echo_t             awaited[$];
		int                fault_count;

		function new();
			shift_dn = 1'b0;
			ctrl_dn = 1'b0;
			alt_dn = 1'b0;
			caps_lk = 1'b0;
			active = '0;
			fault_count = 0;
			for (int t = 0; t < TERMINAL_COUNT; t++) begin
				wipe(t);
				ready[t] = 1'b0;
			end
			plain_map = '{8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
				8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h20, 8'h71, 8'h77, 8'h65, 8'h72,
				8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
				8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
				8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
				8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20};
			upper_map = '{8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
				8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h20, 8'h51, 8'h57, 8'h45, 8'h52,
				8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
				8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
				8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
				8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20};
		endfunction

		function void wipe(int t);
			for (int i = 0; i < LINE_BYTES; i++)
				lines[t][i] = 8'h00;
			widx[t] = '0;
		endfunction

		// Apply one scancode to the active line; return the event and the character
		function ev_t press(input logic [7:0] code, output logic [7:0] ch);
			logic [1:0] t;
			logic [6:0] idx;
			logic [7:0] lo, hi, c;
			int         target;
			t = active;
			idx = widx[t];
			ch = 8'h00;
			// drop modifiers on their release codes
			if (code == SC_LSHIFT_UP || code == SC_RSHIFT_UP) shift_dn = 1'b0;
			if (code == SC_ALT_UP) alt_dn = 1'b0;
			if (code == SC_CTRL_UP) ctrl_dn = 1'b0;
			// enter marks the line without advancing
			if (code == SC_ENTER) begin
				ready[t] = 1'b1;
				lines[t][idx] = CH_NEWLINE;
				ch = CH_NEWLINE;
				return EV_NEWLINE;
			end
			if (code == SC_ALT) alt_dn = 1'b1;
			if (code == SC_CTRL) ctrl_dn = 1'b1;
			if (code == SC_LSHIFT || code == SC_RSHIFT) shift_dn = 1'b1;
			if (code == SC_BKSP) begin
				if (idx == 0) return EV_NONE;
				lines[t][idx] = 8'h00;
				widx[t] = idx - 7'd1;
				return EV_BKSP;
			end
			// alt with a function key selects a terminal
			if (alt_dn && code >= SC_F1 && code <= SC_F3) begin
				target = int'(code) - int'(SC_F1);
				if (target >= TERMINAL_COUNT) return EV_NONE;
				active = target[1:0];
				return EV_SWITCH;
			end
			if (code == 8'h00 || code[7]) return EV_NONE;
			lo = (code < MAP_LEN) ? plain_map[code] : 8'h00;
			hi = (code < MAP_LEN) ? upper_map[code] : 8'h00;
			if (ctrl_dn && (lo == CH_LOW_L || hi == CH_UP_L)) begin
				wipe(t);
				return EV_CLEAR;
			end
			if (code == SC_CAPS) caps_lk = ~caps_lk;
			if (lo == 8'h00 || idx >= LINE_BYTES - 1) return EV_NONE;
			// caps lock shifts letters only
			if (lo >= CH_LOW_A && lo <= CH_LOW_Z)
				c = (caps_lk ^ shift_dn) ? hi : lo;
			else
				c = shift_dn ? hi : lo;
			lines[t][idx] = c;
			widx[t] = idx + 7'd1;
			ch = c;
			return EV_CHAR;
		endfunction

		// Note an accepted request and queue the echo it must produce
		function void apply_request(logic [1:0] req, logic [7:0] code, logic [6:0] pos);
			echo_t e;
			e.ev = EV_NONE;
			e.ch = 8'h00;
			if (active >= TERMINAL_COUNT) active = '0;
			case (req)
				REQ_SCAN: e.ev = press(code, e.ch);
				REQ_READ: begin
					e.ch = lines[active][pos];
					e.ev = EV_READ;
				end
				REQ_CONSUME: begin
					wipe(active);
					ready[active] = 1'b0;
					e.ev = EV_CLEAR;
				end
				default: ;
			endcase
			e.term = active;
			e.fill = widx[active];
			e.ready = ready[active];
			awaited.push_back(e);
		endfunction

		function void compare(string field, logic [7:0] want, logic [7:0] got);
			if (want !== got) begin
				fault_count++;
				$display("ERROR t=%0t %s: expected %0h, got %0h", $time, field, want, got);
			end
		endfunction

		// Check one result against the oldest awaited echo
		function void match_result(logic [2:0] ev, logic [7:0] ch, logic [1:0] term,
			logic [6:0] fill, logic rdy);
			echo_t e;
			if (awaited.size() == 0) begin
				fault_count++;
				$display("ERROR t=%0t unrequested result: expected none, got event %0d",
					$time, ev);
				return;
			end
			e = awaited.pop_front();
			compare("event_res", 8'(e.ev), 8'(ev));
			compare("char_out", e.ch, ch);
			compare("terminal", 8'(e.term), 8'(term));
			compare("fill_count", 8'(e.fill), 8'(fill));
			compare("line_ready", 8'(e.ready), 8'(rdy));
		endfunction

		function int outstanding();
			return awaited.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [1:0] req_type;
	logic [7:0] scancode;
	logic [6:0] read_position;
	logic       done;
	logic [2:0] event_res;
	logic [7:0] char_out;
	logic [1:0] terminal;
	logic [6:0] fill_count;
	logic       line_ready;

	line_editor_shadow shadow;
	int                gap_pct;

	scancode_line_editor_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req_type      (req_type),
		.scancode      (scancode),
		.read_position (read_position),
		.done          (done),
		.event_res     (event_res),
		.char_out      (char_out),
		.terminal      (terminal),
		.fill_count    (fill_count),
		.line_ready    (line_ready)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Hold the request until accepted, with an optional gap before it
	task automatic issue(input logic [1:0] req, input logic [7:0] code, input logic [6:0] pos);
		int gap;
		gap = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 6) : 0;
		@(negedge clk);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		req_type <= req;
		scancode <= code;
		read_position <= pos;
		do @(posedge clk); while (busy);
		shadow.apply_request(req, code, pos);
	endtask

	task automatic key(input logic [7:0] code);
		issue(REQ_SCAN, code, 7'($urandom_range(0, 127)));
	endtask

	// Lower start and hold off until every awaited echo has come
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (shadow.outstanding() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] letter_code();
		int r;
		r = $urandom_range(0, 25);
		if (r < 10) return 8'(16 + r);
		if (r < 19) return 8'(30 + r - 10);
		return 8'(44 + r - 19);
	endfunction

	// Type a long run of letters to push the line to its limit
	task automatic fill_run();
		key(SC_CTRL_UP);
		repeat (132) key(letter_code());
	endtask

	// One random request, weighted towards plausible typing
	task automatic random_request();
		int w;
		logic [7:0] ups [5];
		ups = '{SC_LSHIFT_UP, SC_RSHIFT_UP, SC_CTRL_UP, SC_ALT_UP, SC_CTRL_UP};
		w = $urandom_range(0, 99);
		if (w < 50) key(8'($urandom_range(1, 57)));
		else if (w < 53) key(($urandom_range(0, 1) != 0) ? SC_LSHIFT : SC_RSHIFT);
		else if (w < 54) key(SC_CTRL);
		else if (w < 56) key(SC_ALT);
		else if (w < 61) key(ups[$urandom_range(0, 4)]);
		else if (w < 63) key(SC_CAPS);
		else if (w < 67) key(SC_ENTER);
		else if (w < 72) key(SC_BKSP);
		else if (w < 75) key(8'(SC_F1 + $urandom_range(0, 2)));
		else if (w < 84) issue(REQ_READ, 8'($urandom_range(0, 255)),
			7'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 127) : $urandom_range(0, 15)));
		else if (w < 85) issue(REQ_CONSUME, 8'($urandom_range(0, 255)),
			7'($urandom_range(0, 127)));
		else if (w < 89) key(8'($urandom_range(0, 255)));
		else if (w < 90) issue(REQ_UNKNOWN, 8'($urandom_range(0, 255)),
			7'($urandom_range(0, 127)));
		else if (w < 94) key(8'($urandom_range(58, 127)));
		else key(letter_code());
	endtask

	// Compare every strobed result
	always @(posedge clk) begin
		if (arst_n && done)
			shadow.match_result(event_res, char_out, terminal, fill_count, line_ready);
	end

	initial begin
		#1_500_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		int phase_gap [5];
		phase_gap = '{0, 68, 11, 68, 0};
		shadow = new();
		gap_pct = 0;
		arst_n = 1'b0;
		start = 1'b0;
		req_type = REQ_SCAN;
		scancode = 8'h00;
		read_position = 7'd0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// Directed: empty reads, edge codes, case rules, terminals, clears
		issue(REQ_READ, SC_ANY_UP, 7'd0);
		issue(REQ_READ, SC_NULL, 7'd127);
		key(SC_BKSP);
		key(SC_NULL);
		key(SC_ANY_UP);
		key(SC_LOWEST_UP);
		key(SC_KEY_A);
		key(SC_LSHIFT);
		key(SC_KEY_A);
		key(SC_CAPS);
		key(SC_KEY_A);
		key(SC_KEY_1);
		key(SC_LSHIFT_UP);
		key(SC_KEY_A);
		key(SC_CAPS);
		key(SC_SPACE);
		key(SC_PAST_MAP);
		key(SC_ENTER);
		key(SC_BKSP);
		issue(REQ_READ, SC_KEY_A, 7'd1);
		key(SC_ALT);
		key(SC_F2);
		key(SC_F3);
		key(SC_F1);
		key(SC_ALT_UP);
		key(SC_CTRL);
		key(SC_KEY_L);
		key(SC_CTRL_UP);
		issue(REQ_CONSUME, SC_NULL, 7'd0);
		issue(REQ_UNKNOWN, SC_ANY_UP, 7'd127);
		drain();

		// Random phases with differing sender gaps
		for (int p = 0; p < 5; p++) begin
			int sent;
			gap_pct = phase_gap[p];
			sent = 0;
			if (p == 0 || p == 3) begin
				fill_run();
				sent += 133;
			end
			while (sent < 250) begin
				if ($urandom_range(0, 299) == 0) begin
					fill_run();
					sent += 133;
				end else begin
					random_request();
					sent++;
				end
			end
			drain();
		end

		repeat (20) @(posedge clk);
		if (shadow.fault_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: scancode_line_editor_unit.f
sv/scle_pkg.sv
sv/scle_line_ram.sv
sv/scle_key_decode.sv
sv/scancode_line_editor_unit.sv
test/tb_scancode_line_editor_unit.sv
